// ----- design/ctpt_pkg.sv -----
`timescale 1ns / 1ps

package ctpt_pkg;

    // Buffer type codes
    localparam logic [1:0] BUF_INDEXED = 2'd0;
    localparam logic [1:0] BUF_RGB     = 2'd1;
    localparam logic [1:0] BUF_EGA     = 2'd2;

    // Request kinds carried on tuser
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_WRITE     = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_BUFFER_TYPE   = 3'd0;
    localparam logic [2:0] CFG_PALETTE_COUNT = 3'd1;
    localparam logic [2:0] CFG_RED_BITS      = 3'd2;
    localparam logic [2:0] CFG_GREEN_BITS    = 3'd3;
    localparam logic [2:0] CFG_BLUE_BITS     = 3'd4;
    localparam logic [2:0] CFG_RED_SHIFT     = 3'd5;
    localparam logic [2:0] CFG_GREEN_SHIFT   = 3'd6;
    localparam logic [2:0] CFG_BLUE_SHIFT    = 3'd7;

    localparam logic [31:0] EGA_PIXEL     = 32'h0000_015C;
    localparam logic [31:0] UNKNOWN_PIXEL = 32'hFFFF_FFFF;

    // Start value of the best distance: above any real squared distance
    localparam logic [18:0] DIST_INIT = 19'(4 * 256 * 256);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCALE,
        ST_PACK,
        ST_DONE
    } t_state;

    typedef enum logic {
        UM_DIST,
        UM_SCALE
    } t_unit_mode;

    typedef logic [2:0][7:0]  t_rgb;
    typedef logic [2:0][15:0] t_prod3;

    // Largest code of a field of the given width, width saturated to 8
    function automatic logic [7:0] field_top(input logic [3:0] bits);
        logic [3:0] m;
        logic [8:0] t;
        m = (bits > 4'd8) ? 4'd8 : bits;
        t = (9'd1 << m) - 9'd1;
        return t[7:0];
    endfunction

    // floor(p / 255) for p below 65280
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ----- design/ctpt_palette_mem.sv -----
`timescale 1ns / 1ps

module ctpt_palette_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ctpt_sq_unit.sv -----
`timescale 1ns / 1ps

// Three-lane multiply unit: squares of channel differences or channel scaling
module ctpt_sq_unit (
    input  logic                  i_clk,
    input  ctpt_pkg::t_unit_mode  i_mode,
    input  ctpt_pkg::t_rgb        i_x,
    input  ctpt_pkg::t_rgb        i_y,
    output ctpt_pkg::t_prod3      o_prod
);

    ctpt_pkg::t_prod3 r_prod;
    ctpt_pkg::t_rgb   w_a;
    ctpt_pkg::t_rgb   w_b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_mode == ctpt_pkg::UM_DIST) begin
                w_a[k] = (i_x[k] > i_y[k]) ? (i_x[k] - i_y[k]) : (i_y[k] - i_x[k]);
                w_b[k] = w_a[k];
            end else begin
                w_a[k] = i_x[k];
                w_b[k] = i_y[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= 16'(w_a[k]) * 16'(w_b[k]);
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- design/color_to_pixel_translate_top.sv -----
`timescale 1ns / 1ps

// Channel     Dir  Handshake              Payload
// ----------  ---  ---------------------  ------------------------------------------
// input       in   i_s_tvalid/o_s_tready  tdata: red, green, blue, entry_index
//                                         tuser: command (0 translate, 1 write)
// result      out  o_m_tvalid/i_m_tready  tdata: pixel_value
// config      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Flow: EGA text and unknown types answer straight from idle, direct RGB passes
// through the scale and pack states. Indexed mode searches palette_count entries
// (count saturated to PALETTE_DEPTH), none for an empty palette: the single
// palette read port delivers one entry per cycle into the shared three-lane
// multiply unit, and the read and multiply stages drain before the compare ends.
// Reset: synchronous, active low; control and config registers take their defaults. The
// palette is not cleared, so entries must be written before they are searched.
// Stalls: the result register holds while i_m_tready is low; a new request is
// still taken, and its result waits in the sequencer until the register frees.
module color_to_pixel_translate_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [7:0] red, [15:8] green, [23:16] blue, [31:24] entry_index
    input  logic        i_s_tuser,  // [0] command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [31:0] pixel_value
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    // Configuration registers
    logic [1:0] r_buffer_type;
    logic [8:0] r_palette_count;
    logic [3:0] r_red_bits;
    logic [3:0] r_green_bits;
    logic [3:0] r_blue_bits;
    logic [4:0] r_red_shift;
    logic [4:0] r_green_shift;
    logic [4:0] r_blue_shift;

    // Sequencer and datapath
    ctpt_pkg::t_state r_state;
    ctpt_pkg::t_state n_state;
    ctpt_pkg::t_rgb   r_color;
    logic [8:0]       r_addr;
    logic             r_v1;        // palette read data valid
    logic [AW-1:0]    r_t1;
    logic             r_v2;        // unit products valid
    logic [AW-1:0]    r_t2;
    logic [18:0]      r_best;
    logic [AW-1:0]    r_pick;
    logic [31:0]      r_res;
    logic             r_out_valid;
    logic [31:0]      r_out_data;

    logic             w_s_acc;
    logic             w_cmd;
    logic [8:0]       w_count;
    logic             w_issue;
    logic             w_we;
    logic [23:0]      w_rdata;
    ctpt_pkg::t_rgb   w_entry;
    ctpt_pkg::t_rgb   w_tops;
    ctpt_pkg::t_rgb   w_unit_y;
    ctpt_pkg::t_unit_mode w_unit_mode;
    ctpt_pkg::t_prod3 w_prod;
    logic [17:0]      w_dist;
    logic [31:0]      w_packed;
    logic             w_load_out;

    assign o_s_tready  = (r_state == ctpt_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid & o_s_tready;
    assign w_cmd       = i_s_tuser;

    // Saturate the searched count to the palette depth
    assign w_count = (r_palette_count > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH)
                                                            : r_palette_count;
    assign w_issue = (r_state == ctpt_pkg::ST_SCAN) && (r_addr < w_count);

    // Drop writes beyond the palette
    assign w_we = w_s_acc && (w_cmd == ctpt_pkg::CMD_WRITE)
               && ({1'b0, i_s_tdata[31:24]} < 9'(PALETTE_DEPTH));

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_type   <= ctpt_pkg::BUF_RGB;
            r_palette_count <= 9'd0;
            r_red_bits      <= 4'd8;
            r_green_bits    <= 4'd8;
            r_blue_bits     <= 4'd8;
            r_red_shift     <= 5'd16;
            r_green_shift   <= 5'd8;
            r_blue_shift    <= 5'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ctpt_pkg::CFG_BUFFER_TYPE:   r_buffer_type   <= i_cfg_data[1:0];
                ctpt_pkg::CFG_PALETTE_COUNT: r_palette_count <= i_cfg_data;
                ctpt_pkg::CFG_RED_BITS:      r_red_bits      <= i_cfg_data[3:0];
                ctpt_pkg::CFG_GREEN_BITS:    r_green_bits    <= i_cfg_data[3:0];
                ctpt_pkg::CFG_BLUE_BITS:     r_blue_bits     <= i_cfg_data[3:0];
                ctpt_pkg::CFG_RED_SHIFT:     r_red_shift     <= i_cfg_data[4:0];
                ctpt_pkg::CFG_GREEN_SHIFT:   r_green_shift   <= i_cfg_data[4:0];
                ctpt_pkg::CFG_BLUE_SHIFT:    r_blue_shift    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Palette memory and shared multiply unit
    // ---------------------------------------------------------------------
    ctpt_palette_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_s_tdata[AW+23:24]),
        .i_wdata ({i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]}),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Lane 0 red, lane 1 green, lane 2 blue
    assign w_entry[0] = w_rdata[23:16];
    assign w_entry[1] = w_rdata[15:8];
    assign w_entry[2] = w_rdata[7:0];
    assign w_tops[0]  = ctpt_pkg::field_top(r_red_bits);
    assign w_tops[1]  = ctpt_pkg::field_top(r_green_bits);
    assign w_tops[2]  = ctpt_pkg::field_top(r_blue_bits);

    assign w_unit_mode = (r_state == ctpt_pkg::ST_SCAN) ? ctpt_pkg::UM_DIST
                                                        : ctpt_pkg::UM_SCALE;
    assign w_unit_y    = (r_state == ctpt_pkg::ST_SCAN) ? w_entry : w_tops;

    ctpt_sq_unit u_unit (
        .i_clk  (i_clk),
        .i_mode (w_unit_mode),
        .i_x    (r_color),
        .i_y    (w_unit_y),
        .o_prod (w_prod)
    );

    assign w_dist = 18'(w_prod[0]) + 18'(w_prod[1]) + 18'(w_prod[2]);

    // Scale each channel by its field top over 255 and place it; bits above 31 fall off
    assign w_packed = (32'({24'd0, ctpt_pkg::div255(w_prod[0])}) << r_red_shift)
                    | (32'({24'd0, ctpt_pkg::div255(w_prod[1])}) << r_green_shift)
                    | (32'({24'd0, ctpt_pkg::div255(w_prod[2])}) << r_blue_shift);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_load_out = (r_state == ctpt_pkg::ST_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ctpt_pkg::ST_IDLE: begin
                if (w_s_acc && (w_cmd == ctpt_pkg::CMD_TRANSLATE)) begin
                    case (r_buffer_type)
                        ctpt_pkg::BUF_INDEXED: n_state = ctpt_pkg::ST_SCAN;
                        ctpt_pkg::BUF_RGB:     n_state = ctpt_pkg::ST_SCALE;
                        default:               n_state = ctpt_pkg::ST_DONE;
                    endcase
                end
            end
            ctpt_pkg::ST_SCAN: begin
                // Finish once every entry is issued and the pipeline is empty
                if (!w_issue && !r_v1 && !r_v2) begin
                    n_state = ctpt_pkg::ST_DONE;
                end
            end
            ctpt_pkg::ST_SCALE: n_state = ctpt_pkg::ST_PACK;
            ctpt_pkg::ST_PACK:  n_state = ctpt_pkg::ST_DONE;
            ctpt_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = ctpt_pkg::ST_IDLE;
                end
            end
            default: n_state = ctpt_pkg::ST_IDLE;
        endcase
    end

    // Scan pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_t1 <= r_addr[AW-1:0];
        r_t2 <= r_t1;
        case (r_state)
            ctpt_pkg::ST_IDLE: begin
                r_color[0] <= i_s_tdata[7:0];
                r_color[1] <= i_s_tdata[15:8];
                r_color[2] <= i_s_tdata[23:16];
                r_addr     <= 9'd0;
                r_best     <= ctpt_pkg::DIST_INIT;
                r_pick     <= '0;
                if (r_buffer_type == ctpt_pkg::BUF_EGA) begin
                    r_res <= ctpt_pkg::EGA_PIXEL;
                end else begin
                    r_res <= ctpt_pkg::UNKNOWN_PIXEL;
                end
            end
            ctpt_pkg::ST_SCAN: begin
                if (w_issue) begin
                    r_addr <= r_addr + 9'd1;
                end
                // Strict compare keeps the lowest index on a tie
                if (r_v2 && ({1'b0, w_dist} < r_best)) begin
                    r_best <= {1'b0, w_dist};
                    r_pick <= r_t2;
                end
                r_res <= 32'(r_pick);
            end
            ctpt_pkg::ST_PACK: r_res <= w_packed;
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctpt_pkg::ST_SCAN) |-> (r_addr <= w_count))
        else $error("scan address ran past the palette count");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ctpt_pkg::ST_SCAN) |-> (!r_v1 && !r_v2))
        else $error("scan pipeline busy outside the scan");

    a_best_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctpt_pkg::ST_SCAN && r_v2) |=> (r_best < ctpt_pkg::DIST_INIT))
        else $error("palette entry not taken as best candidate");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctpt_pkg::ST_DONE && r_out_valid && !i_m_tready)
        |=> (r_state == ctpt_pkg::ST_DONE))
        else $error("result left the sequencer while the output was full");

endmodule

// ----- tb/sv/color_to_pixel_translate_top_tb.sv -----
`timescale 1ns / 1ps

module color_to_pixel_translate_top_tb;

    localparam int         DEPTH       = 256;
    localparam logic [1:0] BUF_UNKNOWN = 2'd3;
    localparam int         ITEM_TARGET = 1850;
    localparam int         REPORT_MAX  = 10;

    // One request as it travels on the input stream
    typedef struct packed {
        logic       command;
        logic [7:0] entry_index;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color_req;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data  = '0;

    // Requests waiting for the driver, and the one currently offered
    t_color_req  color_reqs[$];
    t_color_req  cur_req       = '0;
    bit          req_in_flight = 1'b0;

    // Pixel words the block owes, oldest first
    logic [31:0] pending_pixels[$];

    // Shadow of the block: palette contents and register settings
    logic [23:0] pal_rgb[DEPTH];
    bit          pal_loaded[DEPTH];
    logic [1:0]  cfg_type  = ctpt_pkg::BUF_RGB;
    logic [8:0]  cfg_count = 9'd0;
    logic [3:0]  cfg_bits[3]  = '{4'd8, 4'd8, 4'd8};    // red, green, blue
    logic [4:0]  cfg_shift[3] = '{5'd16, 5'd8, 5'd0};

    int send_gap     = 0;
    int recv_gap     = 0;
    bit gaps_on      = 1'b1;
    int fail_count   = 0;
    int items_queued = 0;

    color_to_pixel_translate_top #(
        .PALETTE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Index of the closest loaded entry; strict compare keeps the lowest index on a tie
    function automatic logic [31:0] nearest_entry(input logic [7:0] r, g, b);
        int n, best, pick, dr, dg, db, d;
        n    = (cfg_count > DEPTH) ? DEPTH : cfg_count;
        best = 4 * 256 * 256;
        pick = 0;
        for (int i = 0; i < n; i++) begin
            dr = int'(r) - int'(pal_rgb[i][23:16]);
            dg = int'(g) - int'(pal_rgb[i][15:8]);
            db = int'(b) - int'(pal_rgb[i][7:0]);
            d  = dr * dr + dg * dg + db * db;
            if (d < best) begin
                best = d;
                pick = i;
            end
        end
        return 32'(pick);
    endfunction

    // floor(v * (2^m - 1) / 255) placed at its field; bits above 31 fall off
    function automatic logic [31:0] scaled_field(input logic [7:0] v, input logic [3:0] bits,
                                                 input logic [4:0] shift);
        int unsigned width, code;
        logic [63:0] placed;
        width  = (bits > 4'd8) ? 8 : bits;
        code   = (32'(v) * ((32'd1 << width) - 32'd1)) / 32'd255;
        placed = 64'(code) << shift;
        return placed[31:0];
    endfunction

    function automatic logic [31:0] pixel_for(input logic [7:0] r, g, b);
        case (cfg_type)
            ctpt_pkg::BUF_INDEXED: return nearest_entry(r, g, b);
            ctpt_pkg::BUF_RGB: return scaled_field(r, cfg_bits[0], cfg_shift[0])
                                    | scaled_field(g, cfg_bits[1], cfg_shift[1])
                                    | scaled_field(b, cfg_bits[2], cfg_shift[2]);
            ctpt_pkg::BUF_EGA: return ctpt_pkg::EGA_PIXEL;
            default: return ctpt_pkg::UNKNOWN_PIXEL;
        endcase
    endfunction

    // Apply one accepted request to the shadow: a write loads the palette,
    // a translate owes one pixel word
    function automatic void absorb_request(input t_color_req req);
        if (req.command == ctpt_pkg::CMD_WRITE) begin
            pal_rgb[req.entry_index] = {req.red, req.green, req.blue};
        end else begin
            pending_pixels.push_back(pixel_for(req.red, req.green, req.blue));
        end
    endfunction

    function automatic void flag_fault(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("mismatch: %s, expected 0x%08h, got 0x%08h", what, want, got);
        end
    endfunction

    // Mostly random levels, with a bias toward extremes and mid-scale so
    // palette entries collide and searches tie
    function automatic logic [7:0] some_level();
        case ($urandom_range(0, 8))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] some_width();
        return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    endfunction

    function automatic void queue_color(input logic [7:0] r, g, b);
        t_color_req req;
        req.command     = ctpt_pkg::CMD_TRANSLATE;
        req.red         = r;
        req.green       = g;
        req.blue        = b;
        req.entry_index = 8'($urandom);
        color_reqs.push_back(req);
        items_queued++;
    endfunction

    function automatic void queue_entry(input logic [7:0] idx, r, g, b);
        t_color_req req;
        req.command     = ctpt_pkg::CMD_WRITE;
        req.red         = r;
        req.green       = g;
        req.blue        = b;
        req.entry_index = idx;
        color_reqs.push_back(req);
        pal_loaded[idx] = 1'b1;
        items_queued++;
    endfunction

    // Load every entry the search will read that has never been written
    function automatic void load_prefix();
        int n;
        n = (cfg_count > DEPTH) ? DEPTH : cfg_count;
        if (cfg_type == ctpt_pkg::BUF_INDEXED) begin
            for (int i = 0; i < n; i++) begin
                if (!pal_loaded[i]) begin
                    queue_entry(8'(i), some_level(), some_level(), some_level());
                end
            end
        end
    endfunction

    // Hold until every request is taken and every pixel word has come back,
    // then give a trailing palette write time to land
    task automatic drain_block();
        while (color_reqs.size() != 0 || req_in_flight || pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Unused upper data bits carry noise; the block must mask them
    task automatic write_setting(input logic [2:0] idx, input logic [8:0] val);
        logic [8:0] wdata;
        wdata = 9'($urandom);
        case (idx)
            ctpt_pkg::CFG_BUFFER_TYPE: wdata[1:0] = val[1:0];
            ctpt_pkg::CFG_PALETTE_COUNT: wdata = val;
            ctpt_pkg::CFG_RED_BITS, ctpt_pkg::CFG_GREEN_BITS,
            ctpt_pkg::CFG_BLUE_BITS: wdata[3:0] = val[3:0];
            default: wdata[4:0] = val[4:0];
        endcase
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= wdata;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            ctpt_pkg::CFG_BUFFER_TYPE: cfg_type = wdata[1:0];
            ctpt_pkg::CFG_PALETTE_COUNT: cfg_count = wdata;
            ctpt_pkg::CFG_RED_BITS: cfg_bits[0] = wdata[3:0];
            ctpt_pkg::CFG_GREEN_BITS: cfg_bits[1] = wdata[3:0];
            ctpt_pkg::CFG_BLUE_BITS: cfg_bits[2] = wdata[3:0];
            ctpt_pkg::CFG_RED_SHIFT: cfg_shift[0] = wdata[4:0];
            ctpt_pkg::CFG_GREEN_SHIFT: cfg_shift[1] = wdata[4:0];
            default: cfg_shift[2] = wdata[4:0];
        endcase
    endtask

    task automatic apply_setup(input logic [1:0] bt, input logic [8:0] cnt,
                               input logic [3:0] rb, gb, bb, input logic [4:0] rs, gs, bs);
        write_setting(ctpt_pkg::CFG_BUFFER_TYPE, 9'(bt));
        write_setting(ctpt_pkg::CFG_PALETTE_COUNT, cnt);
        write_setting(ctpt_pkg::CFG_RED_BITS, 9'(rb));
        write_setting(ctpt_pkg::CFG_GREEN_BITS, 9'(gb));
        write_setting(ctpt_pkg::CFG_BLUE_BITS, 9'(bb));
        write_setting(ctpt_pkg::CFG_RED_SHIFT, 9'(rs));
        write_setting(ctpt_pkg::CFG_GREEN_SHIFT, 9'(gs));
        write_setting(ctpt_pkg::CFG_BLUE_SHIFT, 9'(bs));
    endtask

    // One random setting followed by a mix of translates and palette writes.
    // Indexed phases keep the palette small most of the time so searches stay short.
    task automatic random_phase();
        int         pick, n_items;
        logic [1:0] bt;
        logic [8:0] cnt;
        pick = $urandom_range(0, 9);
        bt   = (pick < 4) ? ctpt_pkg::BUF_INDEXED
             : (pick < 8) ? ctpt_pkg::BUF_RGB
             : (pick == 8) ? ctpt_pkg::BUF_EGA : BUF_UNKNOWN;
        cnt  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(17, 256)) : 9'($urandom_range(0, 16));
        drain_block();
        gaps_on = (items_queued < ITEM_TARGET - 250) && ($urandom_range(0, 3) != 0);
        apply_setup(bt, cnt, some_width(), some_width(), some_width(),
                    5'($urandom), 5'($urandom), 5'($urandom));
        load_prefix();
        n_items = (bt == ctpt_pkg::BUF_INDEXED && cnt > 64) ? $urandom_range(4, 12)
                                                            : $urandom_range(30, 90);
        repeat (n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_entry(8'($urandom), some_level(), some_level(), some_level());
            end else begin
                queue_color(some_level(), some_level(), some_level());
            end
        end
    endtask

    // Request driver: on acceptance, update the shadow; then either idle for
    // a random burst or offer the next queued request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                absorb_request(cur_req);
                req_in_flight = 1'b0;
            end
            if (!req_in_flight) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (color_reqs.size() > 0) begin
                    if (gaps_on && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 4);
                    end else begin
                        cur_req       = color_reqs.pop_front();
                        req_in_flight = 1'b1;
                    end
                end
            end
            i_s_tvalid <= req_in_flight;
            i_s_tdata  <= {cur_req.entry_index, cur_req.blue, cur_req.green, cur_req.red};
            i_s_tuser  <= cur_req.command;
        end
    end

    // Result monitor: compare each accepted pixel word with the oldest one
    // owed, and stall the result stream in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_pixels.size() == 0) begin
                    flag_fault("pixel_value with none owed", '0, o_m_tdata);
                end else begin
                    logic [31:0] want;
                    want = pending_pixels.pop_front();
                    if (o_m_tdata !== want) begin
                        flag_fault("pixel_value", want, o_m_tdata);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 4);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: direct RGB, 8 bits per channel at 16/8/0
        queue_color(8'h00, 8'h00, 8'h00);
        queue_color(8'hFF, 8'hFF, 8'hFF);
        queue_color(8'h12, 8'h34, 8'h56);
        queue_entry(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(8'h00, 8'h00, 8'h00, 8'h00);
        drain_block();

        // Empty palette: every search answers index 0
        apply_setup(ctpt_pkg::BUF_INDEXED, 9'd0, 4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0);
        queue_color(8'h80, 8'h80, 8'h80);
        queue_color(8'hFF, 8'h00, 8'hFF);
        drain_block();

        // Ties: entries 0 and 1 are equal, and 5/5/5 is as far from 0 as from 3
        apply_setup(ctpt_pkg::BUF_INDEXED, 9'd4, 4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0);
        queue_entry(8'd0, 8'd10, 8'd10, 8'd10);
        queue_entry(8'd1, 8'd10, 8'd10, 8'd10);
        queue_entry(8'd2, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(8'd3, 8'd0, 8'd0, 8'd0);
        queue_color(8'd10, 8'd10, 8'd10);
        queue_color(8'd0, 8'd0, 8'd0);
        queue_color(8'd5, 8'd5, 8'd5);
        queue_color(8'hFF, 8'hFF, 8'hFA);
        drain_block();

        // Zero-width red, oversized green, one-bit blue, fields pushed past bit 31
        apply_setup(ctpt_pkg::BUF_RGB, 9'd4, 4'd0, 4'd15, 4'd1, 5'd31, 5'd28, 5'd30);
        queue_color(8'hFF, 8'hFF, 8'hFF);
        queue_color(8'd128, 8'd200, 8'd1);
        drain_block();

        apply_setup(ctpt_pkg::BUF_RGB, 9'd4, 4'd5, 4'd6, 4'd5, 5'd11, 5'd5, 5'd0);
        queue_color(8'hFF, 8'd128, 8'd64);
        drain_block();

        apply_setup(ctpt_pkg::BUF_EGA, 9'd4, 4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0);
        queue_color(8'd1, 8'd2, 8'd3);
        drain_block();

        apply_setup(BUF_UNKNOWN, 9'd4, 4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0);
        queue_color(8'd4, 8'd5, 8'd6);
        drain_block();

        // Full palette: an oversized count saturates to the depth
        apply_setup(ctpt_pkg::BUF_INDEXED, 9'd511, 4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0);
        load_prefix();
        repeat (6) queue_color(some_level(), some_level(), some_level());
        drain_block();

        apply_setup(ctpt_pkg::BUF_INDEXED, 9'd256, 4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0);
        repeat (6) queue_color(some_level(), some_level(), some_level());

        while (items_queued < ITEM_TARGET) random_phase();

        drain_block();
        repeat (270) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            flag_fault("pixel_value never delivered", pending_pixels[0], '0);
        end
        if (fail_count == 0) begin
            $display("color_to_pixel_translate_top regression: pass");
        end else begin
            $display("color_to_pixel_translate_top regression: fail");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #20_000_000;
        $display("color_to_pixel_translate_top regression: fail");
        $finish;
    end

endmodule
